>>> hdl/l2h_pkg.sv
package l2h_pkg;

    // Store geometry
    localparam int NUM_BUCKETS = 64;
    localparam int ADDR_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int BKT_W       = 6;
    localparam int CNT_W       = 64;
    localparam int LAT_W       = 64;
    localparam int STEP_W      = 3;
    localparam int DIV_W       = 20;

    // Scaling divisors
    localparam logic [DIV_W-1:0] DIV_MILLI = DIV_W'(1000000);
    localparam logic [DIV_W-1:0] DIV_MICRO = DIV_W'(1000);

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Unit register codes
    localparam logic UNIT_MILLI = 1'b0;
    localparam logic UNIT_MICRO = 1'b1;

    // Input and result words
    typedef struct packed {
        logic             opcode;
        logic [LAT_W-1:0] latency_ns;
        logic [BKT_W-1:0] read_bucket;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0] count_value;
        logic [BKT_W-1:0] bucket_index;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              srch;
        logic [STEP_W-1:0] step;
        logic              rd;
        logic              wb;
    } t_dp_cmd;

endpackage

>>> hdl/l2h_ctrl.sv
module l2h_ctrl
    import l2h_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_opcode,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SRCH = 4'b0010,
        S_RD   = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Next state: search runs bit 5 down to bit 0
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_step  = STEP_W'(BKT_W - 1);
                    n_state = (i_opcode == OP_INSERT) ? S_SRCH : S_RD;
                end
            end
            S_SRCH: begin
                if (r_step == '0) begin
                    n_state = S_RD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_RD: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        o_cmd.srch = (r_state == S_SRCH);
        o_cmd.step = r_step;
        o_cmd.rd   = (r_state == S_RD);
        o_cmd.wb   = (r_state == S_WB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

>>> hdl/l2h_dp.sv
module l2h_dp
    import l2h_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_word  i_word,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output logic      o_done,
    output t_out_word o_result
);

    // Captured word and config
    logic              r_unit;
    logic              r_op;
    logic [LAT_W-1:0]  r_lat;
    logic [BKT_W-1:0]  r_rb;
    logic [BKT_W-1:0]  r_bkt;

    // Counter store with per-entry valid bits
    logic [CNT_W-1:0]  mem [NUM_BUCKETS];
    logic              r_vld [NUM_BUCKETS];
    logic [CNT_W-1:0]  r_rdata;
    logic              r_rhit;

    logic              r_done;
    t_out_word         r_result;

    logic [BKT_W-1:0]  trial;
    logic [BKT_W-1:0]  shamt;
    logic [LAT_W-1:0]  shifted;
    logic [DIV_W-1:0]  divisor;
    logic              ge;
    logic [BKT_W-1:0]  clamped;
    logic [BKT_W-1:0]  sel_idx;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  new_cnt;

    // Search step: bucket >= trial iff (lat >> (trial-1)) >= divisor
    assign divisor = (r_unit == UNIT_MICRO) ? DIV_MICRO : DIV_MILLI;
    assign trial   = r_bkt | (BKT_W'(1) << i_cmd.step);
    assign shamt   = trial - 1'b1;
    assign shifted = r_lat >> shamt;
    assign ge      = (shifted >= LAT_W'(divisor));

    // Clamp to last bucket and select index
    assign clamped  = ({1'b0, r_bkt} >= (BKT_W + 1)'(NUM_BUCKETS))
                      ? BKT_W'(NUM_BUCKETS - 1) : r_bkt;
    assign sel_idx  = (r_op == OP_READ) ? r_rb : clamped;
    assign in_range = ({1'b0, sel_idx} < (BKT_W + 1)'(NUM_BUCKETS));
    assign addr     = ADDR_W'(sel_idx);

    // Count update
    assign cur_cnt = r_rhit ? r_rdata : '0;
    assign new_cnt = cur_cnt + 1'b1;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_MILLI;
        end else if (i_cfg_we) begin
            r_unit <= i_cfg_data;
        end
    end

    // Capture and search
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_word.opcode;
            r_lat <= i_word.latency_ns;
            r_rb  <= i_word.read_bucket;
            r_bkt <= '0;
        end else if (i_cmd.srch && ge) begin
            r_bkt <= trial;
        end
    end

    // Memory read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
        end
        if (i_cmd.wb && (r_op == OP_INSERT)) begin
            mem[addr] <= new_cnt;
        end
    end

    // Valid bits and hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rhit <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_rhit <= in_range && r_vld[addr];
            end
            if (i_cmd.wb && (r_op == OP_INSERT)) begin
                r_vld[addr] <= 1'b1;
            end
        end
    end

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_result.count_value  <= (r_op == OP_INSERT) ? new_cnt : cur_cnt;
            r_result.bucket_index <= sel_idx;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> hdl/log2_latency_histogram.sv
// An insert runs six binary-search steps of the bucket compare (S_SRCH), then the memory read
// (S_RD) and the update (S_WB); a read skips the search. o_done is registered from S_WB.
// No new word is taken while busy; start is taken again in the done cycle.
// The result is held on o_result for the single cycle o_done is high; no back-pressure.
// Synchronous active-low reset: unit = milliseconds, all bucket counts read as zero at once.
module log2_latency_histogram
    import l2h_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_done,
    output t_out_word o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    t_dp_cmd dp_cmd;

    assign o_cfg_ready = !busy;

    // Controller
    l2h_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_cmd.opcode),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    // Datapath
    l2h_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_word     (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

`ifndef ASSERT_OFF
    // A taken word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // Results only appear once the controller is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // One result per word, never two in a row
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");
`endif

endmodule
